>>> rtl/pts_pkg.sv
package pts_pkg;

  // Table geometry and limits
  localparam int NUM_PATTERNS      = 32;
  localparam int MAX_PATTERN_BYTES = 32;
  localparam int MAX_ACTIONS       = 8;

  localparam int IDX_W  = 5;
  localparam int POS_W  = 5;
  localparam int LEN_W  = 6;
  localparam int ENT_W  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int GAP_W  = 10;
  localparam int MC_W   = 4;
  localparam int SLOT_W = 3;
  localparam int PAT_W  = MAX_PATTERN_BYTES * 8;

  localparam logic [GAP_W-1:0] GAP_MAX = '1;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_SUM   = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRB  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_TXT  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             op;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic [7:0]       act;
    logic             last;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        code;
    logic [SLOT_W-1:0] slot;
    logic [GAP_W-1:0]  skipped;
    logic [MC_W-1:0]   total;
    logic              fin;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WB_RD,
    ST_WB_WR,
    ST_SCAN,
    ST_EMIT,
    ST_DROP,
    ST_POST,
    ST_SUM
  } eng_state_t;

endpackage

>>> rtl/phrase_table_command_spotter.sv
// Channel | Ports                                         | Handshake
// input   | in_cmd .. in_last                             | in_push, in_full
// result  | out_kind .. out_final_res                     | out_pop, out_empty
//
// Pattern writes read, merge and write back the word; length/action writes
// finish in ST_IDLE; text bytes go through ST_POST while the 32-byte window
// fills. Each decision sets up in ST_POST, then scans the table through one
// pattern-RAM read port, one entry a cycle. ST_EMIT sends a match, holding
// while the result queue is full; ST_DROP retires its bytes; ST_SUM a summary.
// Synchronous active-low reset clears the queues, window and length table.
// Either side may stall: a 4-word queue sits on each side of the engine.
module phrase_table_command_spotter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_pattern_index,
  input  logic [4:0] in_byte_pos,
  input  logic [7:0] in_data_byte,
  input  logic [5:0] in_pattern_length,
  input  logic [7:0] in_action_in,
  input  logic       in_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_kind,
  output logic [7:0] out_action_code,
  output logic [2:0] out_action_slot,
  output logic [9:0] out_skipped_bytes,
  output logic [3:0] out_action_total,
  output logic       out_final_res
);
  import pts_pkg::*;

  item_t          f_item, e_item;
  logic           f_push, f_full, e_empty, e_pop;
  logic [$bits(item_t)-1:0] e_word;
  res_t           r_res, o_res;
  logic           r_push, r_full;
  logic [$bits(res_t)-1:0]  o_word;

  pts_front u_front (
    .in_push           (in_push),
    .in_cmd            (in_cmd),
    .in_pattern_index  (in_pattern_index),
    .in_byte_pos       (in_byte_pos),
    .in_data_byte      (in_data_byte),
    .in_pattern_length (in_pattern_length),
    .in_action_in      (in_action_in),
    .in_last           (in_last),
    .in_full           (in_full),
    .q_full            (f_full),
    .q_push            (f_push),
    .q_item            (f_item)
  );

  pts_queue #(.WIDTH($bits(item_t)), .DEPTH(4)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_item),
    .full  (f_full),
    .pop   (e_pop),
    .rdata (e_word),
    .empty (e_empty)
  );

  assign e_item = item_t'(e_word);

  pts_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (e_empty),
    .q_item  (e_item),
    .q_pop   (e_pop),
    .o_full  (r_full),
    .o_push  (r_push),
    .o_res   (r_res)
  );

  pts_queue #(.WIDTH($bits(res_t)), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_res),
    .full  (r_full),
    .pop   (out_pop),
    .rdata (o_word),
    .empty (out_empty)
  );

  assign o_res             = res_t'(o_word);
  assign out_kind          = o_res.kind;
  assign out_action_code   = o_res.code;
  assign out_action_slot   = o_res.slot;
  assign out_skipped_bytes = o_res.skipped;
  assign out_action_total  = o_res.total;
  assign out_final_res     = o_res.fin;

  // Summary words and only they close a string
  a_sum_final: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_kind == out_final_res))
    else $error("summary flag and final flag disagree");

  // Match words carry no total
  a_match_total: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == KIND_MATCH)) |-> (out_action_total == '0))
    else $error("match word with nonzero total");

  // Out of reset the command queue is not full and the result queue is empty
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (!in_full && out_empty))
    else $error("queue not cleared by reset");

endmodule

>>> rtl/pts_ram.sv
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pts_queue.sv
module pts_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with wrap
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

>>> rtl/pts_front.sv
module pts_front (
  input  logic                  in_push,
  input  logic [1:0]            in_cmd,
  input  logic [4:0]            in_pattern_index,
  input  logic [4:0]            in_byte_pos,
  input  logic [7:0]            in_data_byte,
  input  logic [5:0]            in_pattern_length,
  input  logic [7:0]            in_action_in,
  input  logic                  in_last,
  output logic                  in_full,
  input  logic                  q_full,
  output logic                  q_push,
  output pts_pkg::item_t        q_item
);
  import pts_pkg::*;

  cmd_t cmd;
  logic keep;

  assign cmd     = cmd_t'(in_cmd);
  assign in_full = q_full;

  // Classify: drop unused commands and out-of-range table writes
  always_comb begin
    unique case (cmd)
      CMD_WRB:  keep = (in_pattern_index < NUM_PATTERNS) && (in_byte_pos < MAX_PATTERN_BYTES);
      CMD_SET:  keep = (in_pattern_index < NUM_PATTERNS);
      CMD_TXT:  keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign q_push = in_push && !q_full && keep;

  // Saturate overlong lengths
  always_comb begin
    q_item.op   = cmd;
    q_item.idx  = in_pattern_index;
    q_item.pos  = in_byte_pos;
    q_item.data = in_data_byte;
    q_item.len  = (in_pattern_length > LEN_W'(MAX_PATTERN_BYTES)) ?
                  LEN_W'(MAX_PATTERN_BYTES) : in_pattern_length;
    q_item.act  = in_action_in;
    q_item.last = in_last;
  end

endmodule

>>> rtl/pts_engine.sv
module pts_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  pts_pkg::item_t q_item,
  output logic           q_pop,
  input  logic           o_full,
  output logic           o_push,
  output pts_pkg::res_t  o_res
);
  import pts_pkg::*;

  eng_state_t        state_r, state_nxt;
  item_t             cur_r, cur_nxt;
  logic [7:0]        win_r [MAX_PATTERN_BYTES];
  logic [7:0]        win_nxt [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic [MC_W-1:0]   mc_r, mc_nxt;
  logic [ENT_W-1:0]  e_r, e_nxt, ce_r, ce_nxt;
  logic              iss_r, iss_nxt, cvld_r, cvld_nxt;
  logic [LEN_W-1:0]  drop_r, drop_nxt;
  res_t              res_r, res_nxt;
  logic [LEN_W-1:0]  len_r [NUM_PATTERNS];
  logic [7:0]        act_r [NUM_PATTERNS];
  logic              tbl_we;

  logic [ENT_W-1:0]       ram_raddr;
  logic [PAT_W-1:0]       ram_rdata, ram_wdata;
  logic                   ram_we;
  logic [LEN_W-1:0]       cur_len;
  logic [MAX_PATTERN_BYTES-1:0] bm;
  logic                   hit, below_max, more;

  pts_ram #(.WIDTH(PAT_W), .DEPTH(NUM_PATTERNS)) u_pat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r.idx[ENT_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = (state_r == ST_WB_RD) ? cur_r.idx[ENT_W-1:0] : e_r;

  // Merge the new byte into the stored pattern word
  always_comb begin
    ram_wdata = ram_rdata;
    ram_wdata[cur_r.pos*8 +: 8] = cur_r.data;
  end

  // Compare the window against the entry read last cycle
  assign cur_len = len_r[ce_r];
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      bm[k] = (LEN_W'(k) >= cur_len) || (win_r[k] == ram_rdata[8*k +: 8]);
    end
  end
  assign hit       = cvld_r && (cur_len != '0) && (FILL_W'(cur_len) <= fill_r) && (&bm);
  assign below_max = (mc_r < MC_W'(MAX_ACTIONS));
  assign more      = below_max && ((fill_r >= FILL_W'(MAX_PATTERN_BYTES)) ||
                     (cur_r.last && (fill_r != '0)));

  assign o_res  = res_r;
  assign o_push = ((state_r == ST_EMIT) || (state_r == ST_SUM)) && !o_full;
  assign q_pop  = (state_r == ST_IDLE) && !q_empty;

  // Next state and datapath
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    gap_nxt   = gap_r;
    mc_nxt    = mc_r;
    e_nxt     = e_r;
    ce_nxt    = ce_r;
    iss_nxt   = iss_r;
    cvld_nxt  = 1'b0;
    drop_nxt  = drop_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    tbl_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          cur_nxt = q_item;
          unique case (q_item.op)
            CMD_WRB: state_nxt = ST_WB_RD;
            CMD_SET: tbl_we = 1'b1;
            default: begin
              // Append a text byte while matches remain and the window has room
              if (below_max && (fill_r < FILL_W'(MAX_PATTERN_BYTES))) begin
                win_nxt[fill_r[FILL_W-2:0]] = q_item.data;
                fill_nxt = fill_r + 1'b1;
              end
              state_nxt = ST_POST;
            end
          endcase
        end
      end
      ST_WB_RD: state_nxt = ST_WB_WR;
      ST_WB_WR: begin
        ram_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_POST: begin
        if (more) begin
          e_nxt     = '0;
          iss_nxt   = 1'b1;
          state_nxt = ST_SCAN;
        end else if (cur_r.last) begin
          res_nxt   = '{kind: KIND_SUM, code: '0, slot: '0, skipped: gap_r,
                        total: mc_r, fin: 1'b1};
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Issue the next entry read
        cvld_nxt = iss_r;
        ce_nxt   = e_r;
        if (iss_r) begin
          if (e_r == ENT_W'(NUM_PATTERNS - 1)) begin
            iss_nxt = 1'b0;
          end else begin
            e_nxt = e_r + 1'b1;
          end
        end
        if (hit) begin
          res_nxt   = '{kind: KIND_MATCH, code: act_r[ce_r], slot: mc_r[SLOT_W-1:0],
                        skipped: gap_r, total: '0, fin: 1'b0};
          mc_nxt    = mc_r + 1'b1;
          gap_nxt   = '0;
          drop_nxt  = cur_len;
          iss_nxt   = 1'b0;
          cvld_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end else if (cvld_r && (ce_r == ENT_W'(NUM_PATTERNS - 1))) begin
          // No entry matches: count a skipped byte and drop it
          if (gap_r != GAP_MAX) begin
            gap_nxt = gap_r + 1'b1;
          end
          for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
            win_nxt[k] = win_r[k+1];
          end
          fill_nxt  = fill_r - 1'b1;
          iss_nxt   = 1'b0;
          cvld_nxt  = 1'b0;
          state_nxt = ST_POST;
        end
      end
      ST_EMIT: begin
        if (!o_full) begin
          state_nxt = ST_DROP;
        end
      end
      ST_DROP: begin
        // Retire the matched bytes one per cycle
        if ((drop_r != '0) && (fill_r != '0)) begin
          for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
            win_nxt[k] = win_r[k+1];
          end
          fill_nxt = fill_r - 1'b1;
          drop_nxt = drop_r - 1'b1;
        end else begin
          state_nxt = ST_POST;
        end
      end
      ST_SUM: begin
        if (!o_full) begin
          fill_nxt  = '0;
          gap_nxt   = '0;
          mc_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      gap_r   <= '0;
      mc_r    <= '0;
      iss_r   <= 1'b0;
      cvld_r  <= 1'b0;
      drop_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      gap_r   <= gap_nxt;
      mc_r    <= mc_nxt;
      iss_r   <= iss_nxt;
      cvld_r  <= cvld_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    win_r <= win_nxt;
    e_r   <= e_nxt;
    ce_r  <= ce_nxt;
    res_r <= res_nxt;
  end

  // Length table clears on reset; action table holds until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        len_r[i] <= '0;
      end
    end else if (tbl_we) begin
      len_r[q_item.idx[ENT_W-1:0]] <= q_item.len;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      act_r[q_item.idx[ENT_W-1:0]] <= q_item.act;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pts_pkg::*;

  // Expected result word
  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [2:0] slot;
    logic [9:0] skipped;
    logic [3:0] total;
    logic       fin;
  } spot_res_t;

  // Scoreboard: spotter predictor plus queue of expected words
  class spot_scoreboard;
    logic [7:0] pat_mem [NUM_PATTERNS][MAX_PATTERN_BYTES];
    int         pat_len [NUM_PATTERNS];
    logic [7:0] pat_act [NUM_PATTERNS];
    logic [7:0] window [$];
    int         gap_cnt;
    int         hit_cnt;
    spot_res_t  pending_words [$];
    int         errors;
    int         checked;
    int         summaries;

    function void clear();
      for (int e = 0; e < NUM_PATTERNS; e++) begin
        pat_len[e] = 0;
        pat_act[e] = '0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) pat_mem[e][k] = '0;
      end
      window.delete();
      gap_cnt = 0;
      hit_cnt = 0;
      errors = 0;
      checked = 0;
      summaries = 0;
    endfunction

    function bit entry_hits(int e);
      if (pat_len[e] == 0 || pat_len[e] > window.size()) return 0;
      for (int k = 0; k < pat_len[e]; k++)
        if (window[k] != pat_mem[e][k]) return 0;
      return 1;
    endfunction

    // Decide the head position: emit a match or count one skipped byte
    function void decide_head();
      spot_res_t r;
      for (int e = 0; e < NUM_PATTERNS; e++) begin
        if (entry_hits(e)) begin
          r = '{1'b0, pat_act[e], 3'(hit_cnt), 10'(gap_cnt), 4'd0, 1'b0};
          pending_words.push_back(r);
          hit_cnt++;
          gap_cnt = 0;
          for (int k = 0; k < pat_len[e] && window.size() > 0; k++)
            void'(window.pop_front());
          return;
        end
      end
      if (gap_cnt < 1023) gap_cnt++;
      void'(window.pop_front());
    endfunction

    function void note_input(cmd_t op, int idx, int pos, logic [7:0] data,
                             int len, logic [7:0] act, logic last);
      spot_res_t r;
      case (op)
        CMD_WRB: pat_mem[idx][pos] = data;
        CMD_SET: begin
          pat_len[idx] = (len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : len;
          pat_act[idx] = act;
        end
        CMD_TXT: begin
          if (hit_cnt < MAX_ACTIONS) begin
            if (window.size() < MAX_PATTERN_BYTES) window.push_back(data);
            while (window.size() >= MAX_PATTERN_BYTES && hit_cnt < MAX_ACTIONS)
              decide_head();
          end
          if (last) begin
            while (window.size() > 0 && hit_cnt < MAX_ACTIONS) decide_head();
            r = '{1'b1, 8'd0, 3'd0, 10'(gap_cnt), 4'(hit_cnt), 1'b1};
            pending_words.push_back(r);
            window.delete();
            gap_cnt = 0;
            hit_cnt = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(spot_res_t got);
      spot_res_t exp_w;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      checked++;
      if (got.kind) summaries++;
      if (got.kind != exp_w.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, exp_w.kind, got.kind);
        errors++;
      end
      if (got.code != exp_w.code) begin
        $display("%0t: action_code expected %0d actual %0d", $time, exp_w.code, got.code);
        errors++;
      end
      if (got.slot != exp_w.slot) begin
        $display("%0t: action_slot expected %0d actual %0d", $time, exp_w.slot, got.slot);
        errors++;
      end
      if (got.skipped != exp_w.skipped) begin
        $display("%0t: skipped_bytes expected %0d actual %0d", $time, exp_w.skipped,
                 got.skipped);
        errors++;
      end
      if (got.total != exp_w.total) begin
        $display("%0t: action_total expected %0d actual %0d", $time, exp_w.total,
                 got.total);
        errors++;
      end
      if (got.fin != exp_w.fin) begin
        $display("%0t: final_res expected %0d actual %0d", $time, exp_w.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [1:0] in_cmd;
  logic [4:0] in_pattern_index;
  logic [4:0] in_byte_pos;
  logic [7:0] in_data_byte;
  logic [5:0] in_pattern_length;
  logic [7:0] in_action_in;
  logic       in_last;
  logic       out_empty;
  logic       out_pop;
  logic       out_kind;
  logic [7:0] out_action_code;
  logic [2:0] out_action_slot;
  logic [9:0] out_skipped_bytes;
  logic [3:0] out_action_total;
  logic       out_final_res;

  spot_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  stall_cycles;
  bit  timed_out;
  int  text_words;

  localparam int STALL_LIMIT = 20000;
  localparam int LOAD_BYTES  = 3;

  phrase_table_command_spotter dut (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver: pop at random, check each word taken
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty)
        sb.check_word('{out_kind, out_action_code, out_action_slot, out_skipped_bytes,
                        out_action_total, out_final_res});
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with nothing accepted
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one word, idling at random first; hold until accepted
  task automatic send_word(cmd_t op, int idx, int pos, int data, int len, int act,
                           bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk);
      in_push <= 1'b0;
    end
    @(posedge clk);
    in_push           <= 1'b1;
    in_cmd            <= op;
    in_pattern_index  <= idx[4:0];
    in_byte_pos       <= pos[4:0];
    in_data_byte      <= data[7:0];
    in_pattern_length <= len[5:0];
    in_action_in      <= act[7:0];
    in_last           <= last;
    do @(posedge clk); while (in_full);
    in_push <= 1'b0;
    sb.note_input(op, idx, pos, 8'(data), len, 8'(act), last);
    if (op == CMD_TXT) text_words++;
  endtask

  // Load the leading bytes of an entry over a small alphabet; lengths stay within them
  task automatic load_pattern(int idx, int len, int act);
    for (int k = 0; k < LOAD_BYTES; k++)
      send_word(CMD_WRB, idx, k, $urandom_range(3), 0, 0, 0);
    send_word(CMD_SET, idx, 0, 0, len, act, 0);
  endtask

  task automatic wait_drained();
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Text string over the same small alphabet so patterns hit often
  task automatic send_text(int n);
    for (int i = 0; i < n; i++)
      send_word(CMD_TXT, $urandom_range(31), $urandom_range(31),
                ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(3),
                $urandom_range(63), $urandom_range(255), i == n - 1);
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 9;
    recv_idle_pct = 62;
    text_words = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_cmd = CMD_NONE;
    in_pattern_index = '0;
    in_byte_pos = '0;
    in_data_byte = '0;
    in_pattern_length = '0;
    in_action_in = '0;
    in_last = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one-byte string, unused command, two-byte string, no entries
    send_word(CMD_TXT, 31, 31, 255, 63, 255, 1);
    send_word(CMD_NONE, 31, 31, 255, 63, 255, 1);
    send_word(CMD_TXT, 0, 0, 0, 0, 0, 0);
    send_word(CMD_TXT, 0, 0, 1, 0, 0, 1);

    // Directed: full-bit pattern bytes, ties on the lowest index, trailing gap
    for (int k = 0; k < 2; k++)
      send_word(CMD_WRB, 30, k, 8'hFF, 0, 0, 0);
    send_word(CMD_WRB, 0, 0, 8'hAA, 0, 0, 0);
    send_word(CMD_WRB, 1, 0, 8'hAA, 0, 0, 0);
    send_word(CMD_SET, 30, 0, 0, 2, 8'h81, 0);
    send_word(CMD_SET, 0, 0, 0, 1, 8'h01, 0);
    send_word(CMD_SET, 1, 0, 0, 1, 8'h02, 0);
    send_word(CMD_TXT, 0, 0, 8'hFF, 0, 0, 0);
    send_word(CMD_TXT, 0, 0, 8'hFF, 0, 0, 0);
    send_word(CMD_TXT, 0, 0, 8'hAA, 0, 0, 0);
    send_word(CMD_TXT, 0, 0, 8'h05, 0, 0, 0);
    send_word(CMD_TXT, 0, 0, 8'hFF, 0, 0, 1);
    // Pause until every expected word has come
    wait_drained();

    // Disable the directed entries, then random short patterns
    send_word(CMD_SET, 0, 0, 0, 0, 0, 0);
    send_word(CMD_SET, 1, 0, 0, 0, 0, 0);
    send_word(CMD_SET, 30, 0, 0, 0, 0, 0);
    for (int e = 2; e < 7; e++)
      load_pattern(e, $urandom_range(LOAD_BYTES, 1), $urandom_range(255));

    // Action limit: one-byte entry that matches every text byte
    send_word(CMD_WRB, 7, 0, 8'h40, 0, 0, 0);
    send_word(CMD_SET, 7, 0, 0, 1, 8'hC7, 0);
    for (int i = 0; i < 11; i++)
      send_word(CMD_TXT, 0, 0, 8'h40, 0, 0, i == 10);

    // Random phases: sender/receiver idle mixes, then none
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 62;
        recv_idle_pct = 9;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int s = 0; s < 2; s++) begin
        int idx;
        if ($urandom_range(3) == 0) begin
          // Table change mid-stream, only to written bytes
          idx = $urandom_range(6, 2);
          send_word(CMD_WRB, idx, $urandom_range(LOAD_BYTES - 1), $urandom_range(3),
                    0, 0, 0);
          send_word(CMD_SET, idx, 0, 0, $urandom_range(LOAD_BYTES), $urandom_range(255),
                    0);
        end
        send_text($urandom_range(8, 1));
      end
    end
    // Long string so decisions happen with a full window
    send_text(34);

    wait_drained();
    $display("Covered %0d text words and %0d result words (%0d summaries).",
             text_words, sb.checked, sb.summaries);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
